// File: src/swrs_pkg.sv
// swrs_pkg: shared types, constants and helpers of the sliding window request stats unit
// no dependencies; imported by every module of the block
package swrs_pkg;

	localparam int unsigned MS_PER_S = 1000;
	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_AW = 1;
	localparam int unsigned Q_CW = 2;
	localparam int unsigned DIV_W = 64;
	localparam int unsigned DIV_CW = 7;
	localparam int unsigned AVG_W = 40;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_RATE_WIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BKT_WIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DUR_WIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ERR_WIN = 3'd3;

	typedef struct packed {
		logic        req_type;
		logic [39:0] now_ms;
		logic [39:0] epoch_sec;
		logic [31:0] elapsed_ms;
		logic        ok;
	} in_item_t;

	typedef struct packed {
		logic [10:0] rate_count;
		logic [39:0] avg_rate_q8;
		logic [31:0] max_bucket_count;
		logic [39:0] avg_duration_q8;
		logic [10:0] error_count;
		logic        overflow;
	} out_item_t;

	typedef enum logic {
		OP_RECORD,
		OP_QUERY
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [39:0] now_ms;
		logic [39:0] epoch_sec;
		logic [31:0] elapsed_ms;
		logic        ok;
	} cmd_t;

	typedef struct packed {
		logic [11:0] rate_window_s;
		logic [9:0]  bucket_window_s;
		logic [11:0] duration_window_s;
		logic [11:0] error_window_s;
	} cfg_t;

	typedef enum logic [1:0] {
		RING_RATE,
		RING_BKT,
		RING_DUR,
		RING_ERR
	} ring_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RATE_PUSH,
		ST_PRUNE_RD,
		ST_PRUNE_CK,
		ST_BK_RD,
		ST_BK_CK,
		ST_DUR_PUSH,
		ST_ERR_PUSH,
		ST_WALK,
		ST_DIV_RATE,
		ST_DIV_DUR,
		ST_OUT
	} st_t;

	function automatic logic [AVG_W-1:0] sat_avg(input logic [DIV_W-1:0] q);
		logic [AVG_W-1:0] r;
		if (q[DIV_W-1:AVG_W] != '0) begin
			r = '1;
		end else begin
			r = q[AVG_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: src/sliding_window_request_stats_unit.sv
// sliding_window_request_stats_unit: top level, configuration registers and assertions
// depends on swrs_pkg, swrs_front and swrs_back
//
// keeps request statistics over sliding time windows. a word with req_type 0 records a
// request (time, epoch second, duration, ok), a word with req_type 1 queries and yields one
// result word on result, marked by done for a single cycle; the receiver cannot hold results
// off, so sample them when done is high. words are taken while busy is low and wait in a
// two-word queue while the back end works. a record holds the back end while it pushes
// into the rings and prunes each in turn; a query holds it while it prunes the rate,
// duration and error rings, walks the held buckets and runs the bit-serial divider for the
// rate average when buckets are held and for the duration average when durations are held;
// done is registered from the output state. write config only while idle.
module sliding_window_request_stats_unit import swrs_pkg::*; #(
	parameter int unsigned RING_DEPTH   = 1024,
	parameter int unsigned BUCKET_DEPTH = 1024,
	parameter int unsigned TIME_WIDTH   = 40
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  in_item_t              item,
	output logic                  done,
	output out_item_t             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t cfg_q;
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	// window registers, writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_window_s     <= 12'd1;
			cfg_q.bucket_window_s   <= 10'd600;
			cfg_q.duration_window_s <= 12'd10;
			cfg_q.error_window_s    <= 12'd60;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_RATE_WIN: cfg_q.rate_window_s     <= cfg_wdata;
				CFG_BKT_WIN:  cfg_q.bucket_window_s   <= cfg_wdata[9:0];
				CFG_DUR_WIN:  cfg_q.duration_window_s <= cfg_wdata;
				CFG_ERR_WIN:  cfg_q.error_window_s    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// front end: accept and classify words
	swrs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// back end: rings, pruning, walk and divide
	swrs_back #(
		.RING_DEPTH   (RING_DEPTH),
		.BUCKET_DEPTH (BUCKET_DEPTH),
		.TIME_WIDTH   (TIME_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.done      (done),
		.result    (result)
	);

`ifndef SYNTH
	// the output state is always followed by idle, so result strobes never touch
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobes on consecutive cycles");

	// an accepted word is visible to the back end next cycle
	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> cmd_valid)
		else $error("accepted word lost before the back end");

	// overflow is sticky across results
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.overflow) |=> result.overflow)
		else $error("overflow flag cleared");
`endif

endmodule

// File: src/swrs_front.sv
// swrs_front: takes input words, classifies them and holds them in a short queue
// depends on swrs_pkg
module swrs_front import swrs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  in_item_t item,
	output logic     busy,
	output logic     cmd_valid,
	output cmd_t     cmd,
	input  logic     cmd_pop
);

	cmd_t            q_mem [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_CW-1:0] cnt_q;
	logic            push;
	cmd_t            cls;

	assign busy      = (cnt_q == Q_CW'(Q_DEPTH));
	assign push      = start && !busy;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_mem[rd_q];

	// classify the word
	always_comb begin
		cls.op          = item.req_type ? OP_QUERY : OP_RECORD;
		cls.now_ms      = item.now_ms;
		cls.epoch_sec   = item.epoch_sec;
		cls.elapsed_ms  = item.elapsed_ms;
		cls.ok          = item.ok;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && cmd_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: src/swrs_div.sv
// swrs_div: restoring divider, one quotient bit per cycle
// depends on swrs_pkg
module swrs_div import swrs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] num,
	input  logic [DIV_W-1:0] den,
	output logic             done,
	output logic [DIV_W-1:0] quo
);

	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  nsh_q;
	logic [DIV_W-1:0]  den_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              run_q;
	logic              done_q;
	logic [DIV_W:0]    trial;
	logic              ge;

	assign trial = {rem_q, nsh_q[DIV_W-1]};
	assign ge    = (trial >= {1'b0, den_q});
	assign done  = done_q;
	assign quo   = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			nsh_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (run_q) begin
			nsh_q <= nsh_q << 1;
			quo_q <= {quo_q[DIV_W-2:0], ge};
			if (ge) begin
				rem_q <= DIV_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[DIV_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= DIV_CW'(DIV_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: src/swrs_back.sv
// swrs_back: ring memories, pruning sequencer, bucket walk and result formatting
// depends on swrs_pkg and swrs_div
module swrs_back import swrs_pkg::*; #(
	parameter int unsigned RING_DEPTH   = 1024,
	parameter int unsigned BUCKET_DEPTH = 1024,
	parameter int unsigned TIME_WIDTH   = 40
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      cmd_valid,
	input  cmd_t      cmd,
	output logic      cmd_pop,
	output logic      done,
	output out_item_t result
);

	localparam int unsigned RA   = $clog2(RING_DEPTH);
	localparam int unsigned RC   = $clog2(RING_DEPTH + 1);
	localparam int unsigned BA   = $clog2(BUCKET_DEPTH);
	localparam int unsigned BC   = $clog2(BUCKET_DEPTH + 1);
	localparam int unsigned TW   = TIME_WIDTH;
	localparam int unsigned SUMW = 32 + RC;
	localparam int unsigned TOTW = 32 + BC;

	function automatic logic [RA-1:0] rinc(input logic [RA-1:0] a);
		return (a == RA'(RING_DEPTH - 1)) ? '0 : a + 1'b1;
	endfunction

	function automatic logic [RA-1:0] rslot(input logic [RA-1:0] h, input logic [RC-1:0] c);
		logic [RA:0] s;
		s = (RA+1)'(h) + (RA+1)'(c);
		if (s >= (RA+1)'(RING_DEPTH)) begin
			s = s - (RA+1)'(RING_DEPTH);
		end
		return s[RA-1:0];
	endfunction

	function automatic logic [BA-1:0] binc(input logic [BA-1:0] a);
		return (a == BA'(BUCKET_DEPTH - 1)) ? '0 : a + 1'b1;
	endfunction

	function automatic logic [BA-1:0] bslot(input logic [BA-1:0] h, input logic [BC-1:0] c);
		logic [BA:0] s;
		s = (BA+1)'(h) + (BA+1)'(c);
		if (s >= (BA+1)'(BUCKET_DEPTH)) begin
			s = s - (BA+1)'(BUCKET_DEPTH);
		end
		return s[BA-1:0];
	endfunction

	// ring memories
	logic [TW-1:0] rate_mem [RING_DEPTH];
	logic [TW-1:0] err_mem  [RING_DEPTH];
	logic [TW-1:0] dtm_mem  [RING_DEPTH];
	logic [31:0]   dval_mem [RING_DEPTH];
	logic [TW-1:0] bsec_mem [BUCKET_DEPTH];
	logic [31:0]   bcnt_mem [BUCKET_DEPTH];

	logic [TW-1:0] rate_rd_q, err_rd_q, dtm_rd_q, bsec_rd_q;
	logic [31:0]   dval_rd_q, bcnt_rd_q;

	st_t   state_q, state_d;
	ring_t ring_q, ring_d;
	cmd_t  cmd_q;

	logic [RA-1:0]   rhead_q, ehead_q, dhead_q;
	logic [RC-1:0]   rcnt_q, ecnt_q, dcnt_q;
	logic [BA-1:0]   bhead_q;
	logic [BC-1:0]   bcnt_q;
	logic [SUMW-1:0] sum_q;
	logic            ovf_q;

	logic [BA-1:0]   widx_q;
	logic [BC-1:0]   issued_q;
	logic            acc_v_q;
	logic            first_v_q;
	logic [TOTW-1:0] total_q;
	logic [31:0]     maxc_q;
	logic [TW-1:0]   first_sec_q, last_sec_q;
	logic [AVG_W-1:0] avg_rate_q, avg_dur_q;
	out_item_t       res_q;
	logic            done_q;

	logic [63:0]   now64, sec64;
	logic [TW-1:0] tnow, tsec;
	logic [21:0]   rate_ms, dur_ms, err_ms;
	logic [TW-1:0] pr_t, pr_ref, pr_win;
	logic          pr_nz, pr_old;
	logic [BA-1:0] bnewest, braddr;
	logic          walk_end;
	logic [63:0]   first64, last64, span_raw, span;

	logic             div_start, div_done;
	logic [DIV_W-1:0] div_num, div_den, div_quo;

	assign now64 = 64'(cmd_q.now_ms);
	assign sec64 = 64'(cmd_q.epoch_sec);
	assign tnow  = now64[TW-1:0];
	assign tsec  = sec64[TW-1:0];

	assign rate_ms = 22'(cfg.rate_window_s) * 22'(MS_PER_S);
	assign dur_ms  = 22'(cfg.duration_window_s) * 22'(MS_PER_S);
	assign err_ms  = 22'(cfg.error_window_s) * 22'(MS_PER_S);

	// oldest-entry test of the ring being pruned
	always_comb begin
		case (ring_q)
			RING_RATE: begin
				pr_t = rate_rd_q; pr_ref = tnow; pr_win = TW'(rate_ms); pr_nz = (rcnt_q != '0);
			end
			RING_BKT: begin
				pr_t = bsec_rd_q; pr_ref = tsec; pr_win = TW'(cfg.bucket_window_s);
				pr_nz = (bcnt_q != '0);
			end
			RING_DUR: begin
				pr_t = dtm_rd_q; pr_ref = tnow; pr_win = TW'(dur_ms); pr_nz = (dcnt_q != '0);
			end
			default: begin
				pr_t = err_rd_q; pr_ref = tnow; pr_win = TW'(err_ms); pr_nz = (ecnt_q != '0);
			end
		endcase
		pr_old = pr_nz && (pr_ref >= pr_win) && (pr_t < pr_ref - pr_win);
	end

	assign bnewest  = bslot(bhead_q, bcnt_q - 1'b1);
	assign walk_end = (issued_q == bcnt_q) && !acc_v_q;

	always_comb begin
		case (state_q)
			ST_BK_RD: braddr = bnewest;
			ST_WALK:  braddr = widx_q;
			default:  braddr = bhead_q;
		endcase
	end

	// bucket span, at least one second
	assign first64  = 64'(first_sec_q);
	assign last64   = 64'(last_sec_q);
	assign span_raw = last64 - first64 + 64'd1;
	assign span     = (last64 >= first64 && span_raw != '0) ? span_raw : 64'd1;

	always_comb begin
		if (state_q == ST_WALK) begin
			div_num = DIV_W'(total_q) << 8;
			div_den = span;
		end else begin
			div_num = DIV_W'(sum_q) << 8;
			div_den = DIV_W'(dcnt_q);
		end
	end

	swrs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ring_q  <= RING_RATE;
		end else begin
			state_q <= state_d;
			ring_q  <= ring_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ring_d    = ring_q;
		cmd_pop   = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					ring_d  = RING_RATE;
					state_d = (cmd.op == OP_QUERY) ? ST_PRUNE_RD : ST_RATE_PUSH;
				end
			end
			ST_RATE_PUSH: state_d = ST_PRUNE_RD;
			ST_PRUNE_RD:  state_d = ST_PRUNE_CK;
			ST_PRUNE_CK: begin
				if (pr_old) begin
					state_d = ST_PRUNE_RD;
				end else if (cmd_q.op == OP_RECORD) begin
					case (ring_q)
						RING_RATE: state_d = ST_BK_RD;
						RING_BKT:  state_d = ST_DUR_PUSH;
						RING_DUR:  state_d = ST_ERR_PUSH;
						default:   state_d = ST_IDLE;
					endcase
				end else begin
					case (ring_q)
						RING_RATE: begin
							ring_d = RING_DUR; state_d = ST_PRUNE_RD;
						end
						RING_DUR: begin
							ring_d = RING_ERR; state_d = ST_PRUNE_RD;
						end
						default: state_d = ST_WALK;
					endcase
				end
			end
			ST_BK_RD: state_d = ST_BK_CK;
			ST_BK_CK: begin
				ring_d = RING_BKT; state_d = ST_PRUNE_RD;
			end
			ST_DUR_PUSH: begin
				ring_d = RING_DUR; state_d = ST_PRUNE_RD;
			end
			ST_ERR_PUSH: begin
				ring_d = RING_ERR; state_d = ST_PRUNE_RD;
			end
			ST_WALK: begin
				if (walk_end) begin
					if (bcnt_q != '0) begin
						div_start = 1'b1;
						state_d   = ST_DIV_RATE;
					end else if (dcnt_q != '0) begin
						div_start = 1'b1;
						state_d   = ST_DIV_DUR;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_DIV_RATE: begin
				if (div_done) begin
					if (dcnt_q != '0) begin
						div_start = 1'b1;
						state_d   = ST_DIV_DUR;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_DIV_DUR: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory writes and registered reads
	always_ff @(posedge clk) begin
		rate_rd_q <= rate_mem[rhead_q];
		err_rd_q  <= err_mem[ehead_q];
		dtm_rd_q  <= dtm_mem[dhead_q];
		dval_rd_q <= dval_mem[dhead_q];
		bsec_rd_q <= bsec_mem[braddr];
		bcnt_rd_q <= bcnt_mem[braddr];
		if (state_q == ST_RATE_PUSH) begin
			rate_mem[(rcnt_q == RC'(RING_DEPTH)) ? rhead_q : rslot(rhead_q, rcnt_q)] <= tnow;
		end
		if (state_q == ST_ERR_PUSH && !cmd_q.ok) begin
			err_mem[(ecnt_q == RC'(RING_DEPTH)) ? ehead_q : rslot(ehead_q, ecnt_q)] <= tnow;
		end
		if (state_q == ST_DUR_PUSH) begin
			dtm_mem[(dcnt_q == RC'(RING_DEPTH)) ? dhead_q : rslot(dhead_q, dcnt_q)]  <= tnow;
			dval_mem[(dcnt_q == RC'(RING_DEPTH)) ? dhead_q : rslot(dhead_q, dcnt_q)] <=
				cmd_q.elapsed_ms;
		end
		if (state_q == ST_BK_CK) begin
			if (bcnt_q != '0 && bsec_rd_q == tsec) begin
				if (bcnt_rd_q != '1) begin
					bcnt_mem[bnewest] <= bcnt_rd_q + 32'd1;
				end
			end else begin
				bsec_mem[(bcnt_q == BC'(BUCKET_DEPTH)) ? bhead_q : bslot(bhead_q, bcnt_q)] <= tsec;
				bcnt_mem[(bcnt_q == BC'(BUCKET_DEPTH)) ? bhead_q : bslot(bhead_q, bcnt_q)] <= 32'd1;
			end
		end
	end

	// payload registers of the walk and the result
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_PRUNE_CK && state_d == ST_WALK) begin
			widx_q      <= bhead_q;
			issued_q    <= '0;
			total_q     <= '0;
			maxc_q      <= '0;
			first_v_q   <= 1'b1;
			first_sec_q <= '0;
			last_sec_q  <= '0;
			avg_rate_q  <= '0;
			avg_dur_q   <= '0;
		end
		if (state_q == ST_WALK) begin
			if (issued_q != bcnt_q) begin
				widx_q   <= binc(widx_q);
				issued_q <= issued_q + 1'b1;
			end
			if (acc_v_q) begin
				total_q    <= total_q + TOTW'(bcnt_rd_q);
				last_sec_q <= bsec_rd_q;
				first_v_q  <= 1'b0;
				if (bcnt_rd_q > maxc_q) begin
					maxc_q <= bcnt_rd_q;
				end
				if (first_v_q) begin
					first_sec_q <= bsec_rd_q;
				end
			end
		end
		if (state_q == ST_DIV_RATE && div_done) begin
			avg_rate_q <= sat_avg(div_quo);
		end
		if (state_q == ST_DIV_DUR && div_done) begin
			avg_dur_q <= sat_avg(div_quo);
		end
		if (state_q == ST_OUT) begin
			res_q.rate_count       <= 11'(rcnt_q);
			res_q.avg_rate_q8      <= avg_rate_q;
			res_q.max_bucket_count <= maxc_q;
			res_q.avg_duration_q8  <= avg_dur_q;
			res_q.error_count      <= 11'(ecnt_q);
			res_q.overflow         <= ovf_q;
		end
	end

	// ring pointers, running sum, overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rhead_q <= '0; rcnt_q <= '0;
			ehead_q <= '0; ecnt_q <= '0;
			dhead_q <= '0; dcnt_q <= '0;
			bhead_q <= '0; bcnt_q <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
			acc_v_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q  <= (state_q == ST_OUT);
			acc_v_q <= (state_q == ST_WALK) && (issued_q != bcnt_q);
			case (state_q)
				ST_RATE_PUSH: begin
					if (rcnt_q == RC'(RING_DEPTH)) begin
						rhead_q <= rinc(rhead_q);
						ovf_q   <= 1'b1;
					end else begin
						rcnt_q <= rcnt_q + 1'b1;
					end
				end
				ST_ERR_PUSH: begin
					if (!cmd_q.ok) begin
						if (ecnt_q == RC'(RING_DEPTH)) begin
							ehead_q <= rinc(ehead_q);
							ovf_q   <= 1'b1;
						end else begin
							ecnt_q <= ecnt_q + 1'b1;
						end
					end
				end
				ST_DUR_PUSH: begin
					if (dcnt_q == RC'(RING_DEPTH)) begin
						dhead_q <= rinc(dhead_q);
						ovf_q   <= 1'b1;
						sum_q   <= sum_q - SUMW'(dval_rd_q) + SUMW'(cmd_q.elapsed_ms);
					end else begin
						dcnt_q <= dcnt_q + 1'b1;
						sum_q  <= sum_q + SUMW'(cmd_q.elapsed_ms);
					end
				end
				ST_BK_CK: begin
					if (!(bcnt_q != '0 && bsec_rd_q == tsec)) begin
						if (bcnt_q == BC'(BUCKET_DEPTH)) begin
							bhead_q <= binc(bhead_q);
							ovf_q   <= 1'b1;
						end else begin
							bcnt_q <= bcnt_q + 1'b1;
						end
					end
				end
				ST_PRUNE_CK: begin
					if (pr_old) begin
						case (ring_q)
							RING_RATE: begin
								rhead_q <= rinc(rhead_q); rcnt_q <= rcnt_q - 1'b1;
							end
							RING_BKT: begin
								bhead_q <= binc(bhead_q); bcnt_q <= bcnt_q - 1'b1;
							end
							RING_DUR: begin
								dhead_q <= rinc(dhead_q); dcnt_q <= dcnt_q - 1'b1;
								sum_q   <= sum_q - SUMW'(dval_rd_q);
							end
							default: begin
								ehead_q <= rinc(ehead_q); ecnt_q <= ecnt_q - 1'b1;
							end
						endcase
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// File: dv/sliding_window_request_stats_unit_tb.sv
// sliding_window_request_stats_unit_tb: self-checking testbench of the request stats unit
// depends on swrs_pkg and sliding_window_request_stats_unit; carries its own ring predictor
module sliding_window_request_stats_unit_tb;
	import swrs_pkg::*;

	localparam int unsigned DEPTH = 1024;
	localparam longint unsigned M40 = 64'hFF_FFFF_FFFF;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd5;
	// worst record or query may prune every entry of its rings; be generous
	localparam int unsigned SETTLE_CYCLES = 10000;
	localparam longint unsigned CYCLE_LIMIT = 3000000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t item;
	logic done;
	out_item_t result;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	sliding_window_request_stats_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// clock, 20 units per period
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state: one time array per ring, indexed by ring_t
	longint unsigned ring_time [4][DEPTH];
	int unsigned ring_head [4];
	int unsigned ring_cnt [4];
	longint unsigned bkt_count [DEPTH];
	longint unsigned dur_val [DEPTH];
	longint unsigned dur_sum;
	bit drop_seen;
	longint unsigned win_rate, win_bkt, win_dur, win_err;

	out_item_t stats_pending[$];
	int unsigned n_fail;
	longint unsigned cycles;

	// stimulus cursors
	longint unsigned t_ms, ep_base;
	int unsigned burst_left;
	bit gaps_on;

	function automatic bit too_old(longint unsigned t, longint unsigned now, longint unsigned w);
		return now >= w && t < now - w;
	endfunction

	// slot for a new newest entry; a full ring loses its oldest entry
	function automatic int unsigned ring_push(ring_t r);
		int unsigned slot;
		if (ring_cnt[r] >= DEPTH) begin
			ring_head[r] = (ring_head[r] + 1) % DEPTH;
			ring_cnt[r] = DEPTH - 1;
			drop_seen = 1'b1;
		end
		slot = (ring_head[r] + ring_cnt[r]) % DEPTH;
		ring_cnt[r]++;
		return slot;
	endfunction

	function automatic void ring_prune(ring_t r, longint unsigned now, longint unsigned w);
		while (ring_cnt[r] > 0 && too_old(ring_time[r][ring_head[r]], now, w)) begin
			if (r == RING_DUR)
				dur_sum -= dur_val[ring_head[r]];
			ring_head[r] = (ring_head[r] + 1) % DEPTH;
			ring_cnt[r]--;
		end
	endfunction

	function automatic void stats_reset();
		for (int i = 0; i < 4; i++) begin
			ring_head[i] = 0;
			ring_cnt[i] = 0;
		end
		dur_sum = 0;
		drop_seen = 1'b0;
		win_rate = 1;
		win_bkt = 600;
		win_dur = 10;
		win_err = 60;
	endfunction

	// advance the statistics by one accepted word; queries queue a result
	function automatic void stats_update(in_item_t w);
		longint unsigned now, sec, total, maxc, first, last, span, avg;
		int unsigned s, k;
		out_item_t o;
		now = 64'(w.now_ms);
		sec = 64'(w.epoch_sec);
		if (w.req_type == OP_RECORD) begin
			s = ring_push(RING_RATE);
			ring_time[RING_RATE][s] = now;
			ring_prune(RING_RATE, now, win_rate * 1000);
			// merge into the newest bucket when the second matches
			s = (ring_head[RING_BKT] + ring_cnt[RING_BKT] + DEPTH - 1) % DEPTH;
			if (ring_cnt[RING_BKT] > 0 && ring_time[RING_BKT][s] == sec) begin
				if (bkt_count[s] != 64'hFFFF_FFFF)
					bkt_count[s]++;
			end else begin
				s = ring_push(RING_BKT);
				ring_time[RING_BKT][s] = sec;
				bkt_count[s] = 1;
			end
			ring_prune(RING_BKT, sec, win_bkt);
			if (ring_cnt[RING_DUR] >= DEPTH)
				dur_sum -= dur_val[ring_head[RING_DUR]];
			s = ring_push(RING_DUR);
			ring_time[RING_DUR][s] = now;
			dur_val[s] = 64'(w.elapsed_ms);
			dur_sum += 64'(w.elapsed_ms);
			ring_prune(RING_DUR, now, win_dur * 1000);
			if (!w.ok) begin
				s = ring_push(RING_ERR);
				ring_time[RING_ERR][s] = now;
			end
			ring_prune(RING_ERR, now, win_err * 1000);
			return;
		end
		ring_prune(RING_RATE, now, win_rate * 1000);
		ring_prune(RING_DUR, now, win_dur * 1000);
		ring_prune(RING_ERR, now, win_err * 1000);
		o = '0;
		if (ring_cnt[RING_BKT] > 0) begin
			total = 0;
			maxc = 0;
			for (int unsigned i = 0; i < ring_cnt[RING_BKT]; i++) begin
				k = (ring_head[RING_BKT] + i) % DEPTH;
				total += bkt_count[k];
				if (bkt_count[k] > maxc)
					maxc = bkt_count[k];
			end
			first = ring_time[RING_BKT][ring_head[RING_BKT]];
			last = ring_time[RING_BKT][(ring_head[RING_BKT] + ring_cnt[RING_BKT] - 1) % DEPTH];
			span = (last >= first) ? last - first + 1 : 1;
			avg = (total << 8) / span;
			o.avg_rate_q8 = 40'((avg > M40) ? M40 : avg);
			o.max_bucket_count = 32'(maxc);
		end
		if (ring_cnt[RING_DUR] > 0) begin
			avg = (dur_sum << 8) / ring_cnt[RING_DUR];
			o.avg_duration_q8 = 40'((avg > M40) ? M40 : avg);
		end
		o.rate_count = 11'(ring_cnt[RING_RATE]);
		o.error_count = 11'(ring_cnt[RING_ERR]);
		o.overflow = drop_seen;
		stats_pending.insert(stats_pending.size(), o);
	endfunction

	// result checker: done marks a word valid for exactly this cycle
	task automatic check_field(string name, longint unsigned exp, longint unsigned act);
		if (exp != act) begin
			$error("%s: expected %0d, got %0d", name, exp, act);
			n_fail++;
		end
	endtask

	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && done) begin
			if (stats_pending.size() == 0) begin
				$error("result word with nothing expected");
				n_fail++;
			end else begin
				e = stats_pending[0];
				stats_pending.delete(0);
				check_field("rate_count", e.rate_count, result.rate_count);
				check_field("avg_rate_q8", e.avg_rate_q8, result.avg_rate_q8);
				check_field("max_bucket_count", e.max_bucket_count, result.max_bucket_count);
				check_field("avg_duration_q8", e.avg_duration_q8, result.avg_duration_q8);
				check_field("error_count", e.error_count, result.error_count);
				check_field("overflow", e.overflow, result.overflow);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// send one word; start stays high while a burst runs
	task automatic send_word(in_item_t w);
		int unsigned gap;
		@(negedge clk);
		start <= 1'b1;
		item <= w;
		do @(posedge clk); while (busy);
		stats_update(w);
		if (burst_left > 0) begin
			burst_left--;
		end else if (gaps_on) begin
			burst_left = $urandom_range(0, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				@(negedge clk);
				start <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// drop start, let every result arrive, then give records time to finish pruning
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (stats_pending.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_RATE_WIN: win_rate = 64'(val);
			CFG_BKT_WIN: win_bkt = 64'(val[9:0]);
			CFG_DUR_WIN: win_dur = 64'(val);
			CFG_ERR_WIN: win_err = 64'(val);
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_windows(int unsigned r, int unsigned b, int unsigned d, int unsigned e);
		write_reg(CFG_RATE_WIN, CFG_DATA_W'(r));
		write_reg(CFG_BKT_WIN, CFG_DATA_W'(b));
		write_reg(CFG_DUR_WIN, CFG_DATA_W'(d));
		write_reg(CFG_ERR_WIN, CFG_DATA_W'(e));
	endtask

	function automatic in_item_t make_word(bit query, longint unsigned now,
			longint unsigned sec, longint unsigned dur, bit good);
		in_item_t w;
		w.req_type = query ? OP_QUERY : OP_RECORD;
		w.now_ms = 40'(now);
		w.epoch_sec = 40'(sec);
		w.elapsed_ms = 32'(dur);
		w.ok = good;
		return w;
	endfunction

	// random word: mostly forward time in small steps, some jumps, a few steps back
	function automatic in_item_t rand_word(int unsigned query_pct);
		int unsigned r;
		longint unsigned step, sec, dur;
		r = $urandom_range(0, 99);
		if (r < 70)
			step = $urandom_range(0, 400);
		else if (r < 90)
			step = $urandom_range(0, 5000);
		else if (r < 97)
			step = $urandom_range(0, 200000);
		else
			step = 0;
		if (r >= 97) begin
			step = $urandom_range(0, 2000);
			t_ms = (t_ms > step) ? t_ms - step : 0;
		end else begin
			t_ms = (t_ms + step) & M40;
		end
		sec = (ep_base + t_ms / 1000) & M40;
		if ($urandom_range(0, 19) == 0)
			sec = (sec + $urandom_range(0, 6) - 3) & M40;
		dur = ($urandom_range(0, 3) == 0) ? {$urandom} : $urandom_range(0, 2000);
		return make_word($urandom_range(0, 99) < query_pct, t_ms, sec, dur,
			$urandom_range(0, 4) != 0);
	endfunction

	task automatic run_random(int unsigned n, int unsigned query_pct);
		repeat (n) send_word(rand_word(query_pct));
	endtask

	// empty rings, extremes of every field, early, backward and saturating cases
	task automatic test_directed();
		send_word(make_word(1, 0, 0, 0, 1));                 // empty rings report zero
		send_word(make_word(0, 0, 0, 0, 1));                 // early time: nothing pruned
		send_word(make_word(0, 5, 0, 64'hFFFF_FFFF, 0));     // max duration, error
		send_word(make_word(1, 10, 0, 0, 1));
		send_word(make_word(0, 2000, 3, 64'hFFFF_FFFF, 0));
		send_word(make_word(0, 1500, 3, 7, 1));              // backward time stays
		send_word(make_word(1, 2100, 0, 0, 1));
		send_word(make_word(0, 2200, 1, 100, 1));            // backward epoch: a new bucket, span 2
		send_word(make_word(1, 2300, 0, 0, 1));
		send_word(make_word(0, 2400, 1, 100, 0));            // merges into the newest bucket
		send_word(make_word(1, 70000, 0, 0, 1));             // all time rings pruned
		send_word(make_word(0, M40 - 100, M40, 64'hFFFF_FFFF, 0));
		send_word(make_word(0, M40 - 50, M40, 64'hFFFF_FFFF, 0));
		send_word(make_word(1, M40, M40, 0, 0));             // maximum duration average, below saturation
		send_word(make_word(0, M40, M40, 0, 1));
		send_word(make_word(1, M40, 0, 64'hFFFF_FFFF, 1));
		settle();
	endtask

	// register extremes: minimum, maximum, zero and masked writes
	task automatic test_windows();
		write_windows(1, 1, 1, 1);
		t_ms = 1000;
		ep_base = 0;
		run_random(150, 25);
		settle();
		write_windows(3600, 1023, 3600, 3600);
		run_random(150, 25);
		settle();
		// zero windows prune everything older than the word itself
		write_windows(0, 0, 0, 0);
		run_random(120, 30);
		// pause with start low until every result is back, then carry on
		settle();
		write_reg(CFG_SPARE_IDX, 12'd77);                    // unused index is ignored
		write_reg(CFG_BKT_WIN, 12'hC05);                     // upper bits dropped
		write_reg(CFG_RATE_WIN, 12'd2);
		write_reg(CFG_DUR_WIN, 12'd3);
		write_reg(CFG_ERR_WIN, 12'd5);
		run_random(150, 25);
		settle();
	endtask

	// more records than a ring holds, then every time ring pruned at once
	task automatic test_ring_full();
		write_windows(3600, 1023, 3600, 3600);
		gaps_on = 1'b0;
		for (int i = 0; i < 1100; i++) begin
			t_ms = (t_ms + $urandom_range(0, 3)) & M40;
			send_word(make_word((i % 40) == 39, t_ms, (ep_base + t_ms / 10) & M40,
				{$urandom}, $urandom_range(0, 1) != 0));
		end
		gaps_on = 1'b1;
		t_ms = (t_ms + 64'd4_000_000) & M40;
		send_word(make_word(1, t_ms, 0, 0, 1));
		settle();
	endtask

	// random traffic in the upper part of the time range
	task automatic test_high_time();
		write_windows(60, 120, 30, 300);
		t_ms = M40 - 64'd20_000_000 - $urandom_range(0, 1000000);
		ep_base = M40 - 64'd100_000;
		run_random(200, 25);
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_idx = CFG_RATE_WIN;
		cfg_wdata = '0;
		n_fail = 0;
		cycles = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		t_ms = 0;
		ep_base = 0;
		stats_reset();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_windows();
		test_ring_full();
		test_high_time();
		if (n_fail == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/swrs_pkg.sv
src/swrs_front.sv
src/swrs_div.sv
src/swrs_back.sv
src/sliding_window_request_stats_unit.sv
dv/sliding_window_request_stats_unit_tb.sv
